@@ rtl/foa_pkg.sv @@
// ---------------------------------------------------------------------------
// foa_pkg
// Codes, fixed field widths and the sequencer state type shared by the
// frame ownership allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package foa_pkg;

    localparam int ACTION_W    = 3;
    localparam int FILE_ID_W   = 10;
    localparam int OFFSET_W    = 26;
    localparam int STATUS_W    = 2;
    localparam int CART_OUT_W  = 6;
    localparam int FRAME_OUT_W = 10;
    localparam int POS_OUT_W   = 10;
    localparam int OWNER_W     = 10;

    localparam logic [ACTION_W-1:0] ACT_OPEN    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_EXTEND  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_NEXT    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_RELEASE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_SEEK    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_AT_END = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NONE   = 2'd2;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_LOAD  = 7'b0000100,
        S_SETUP = 7'b0001000,
        S_SCAN  = 7'b0010000,
        S_WB    = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

endpackage

`default_nettype wire

@@ rtl/frame_ownership_allocator.sv @@
// ---------------------------------------------------------------------------
// frame_ownership_allocator
// Owner table of storage frames with a cursor and an end frame per file.
//
// Input channel (i_valid / o_ready) carries one item: action, file id and
// byte offset. Output channel (o_valid / i_ready) returns one result item per
// input item: status, cartridge, frame and byte position of the cursor.
// One item at a time: o_ready is high only while the block is idle, and the
// result is held in registers until the receiver takes it; a stalled
// receiver keeps the block busy and no new item is accepted.
// Sequence: an item whose file id is invalid goes straight from accept to
// the result; an unknown action or a next already at its end frame passes
// the file table read and write-back. Other items then visit owner table
// entries one at a time through the single owner table read port; release
// and failed seeks walk the whole table from its start. Every owner entry
// passes one shared compare, and seek walks its offset down with one shared
// compare and subtract.
// Reset: a clearing pass over max(CARTRIDGES*FRAMES_PER_CARTRIDGE, MAX_FILES)
// addresses zeroes the owner table and the file table; o_ready stays low
// until it has finished.
// ---------------------------------------------------------------------------
`default_nettype none

module frame_ownership_allocator #(
    parameter int CARTRIDGES           = 64,
    parameter int FRAMES_PER_CARTRIDGE = 1024,
    parameter int MAX_FILES            = 1024,
    parameter int FRAME_BYTES          = 1024
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_ready,
    input  wire  [foa_pkg::ACTION_W-1:0]       i_action,
    input  wire  [foa_pkg::FILE_ID_W-1:0]      i_file_id,
    input  wire  [foa_pkg::OFFSET_W-1:0]       i_offset,
    output logic                               o_valid,
    input  wire                                i_ready,
    output logic [foa_pkg::STATUS_W-1:0]       o_status,
    output logic [foa_pkg::CART_OUT_W-1:0]     o_cartridge,
    output logic [foa_pkg::FRAME_OUT_W-1:0]    o_frame,
    output logic [foa_pkg::POS_OUT_W-1:0]      o_position
);

    localparam int TABLE = CARTRIDGES * FRAMES_PER_CARTRIDGE;
    localparam int CLR_N = (TABLE > MAX_FILES) ? TABLE : MAX_FILES;
    localparam int CLRW  = $clog2(CLR_N);
    localparam int SW    = $clog2(TABLE);
    localparam int SCW   = $clog2(TABLE + 2);
    localparam int CW    = (CARTRIDGES > 1) ? $clog2(CARTRIDGES) : 1;
    localparam int CCW   = $clog2(CARTRIDGES + 1);
    localparam int FW    = $clog2(FRAMES_PER_CARTRIDGE);
    localparam int FCW   = $clog2(FRAMES_PER_CARTRIDGE + 1);
    localparam int PW    = $clog2(FRAME_BYTES);
    localparam int FAW   = $clog2(MAX_FILES);
    localparam int OFW   = foa_pkg::OFFSET_W;

    typedef struct packed {
        logic [CW-1:0] cur_c;
        logic [FW-1:0] cur_f;
        logic [PW-1:0] cur_p;
        logic [CW-1:0] end_c;
        logic [FW-1:0] end_f;
    } t_fstate;

    foa_pkg::t_state r_state, n_state;
    logic [CLRW-1:0]                  r_clr, n_clr;
    logic [foa_pkg::ACTION_W-1:0]     r_action, n_action;
    logic [foa_pkg::FILE_ID_W-1:0]    r_fid, n_fid;
    logic [foa_pkg::OFFSET_W-1:0]     r_offset, n_offset;
    logic [foa_pkg::OFFSET_W-1:0]     r_rem, n_rem;
    logic [CW-1:0]                    r_cur_c, n_cur_c;
    logic [FW-1:0]                    r_cur_f, n_cur_f;
    logic [PW-1:0]                    r_cur_p, n_cur_p;
    logic [CW-1:0]                    r_end_c, n_end_c;
    logic [FW-1:0]                    r_end_f, n_end_f;
    logic [foa_pkg::STATUS_W-1:0]     r_status, n_status;
    logic [CCW-1:0]                   r_c, n_c;
    logic [FW-1:0]                    r_f, n_f;
    logic [SCW-1:0]                   r_slot, n_slot;
    logic                             r_skip0, n_skip0;
    logic                             r_pv, n_pv;
    logic [CCW-1:0]                   r_pc, n_pc;
    logic [FW-1:0]                    r_pf, n_pf;
    logic [SCW-1:0]                   r_pslot, n_pslot;

    logic [foa_pkg::OWNER_W-1:0]      r_owner_mem [TABLE];
    logic [foa_pkg::OWNER_W-1:0]      r_owner_rd;
    t_fstate                          r_file_mem [MAX_FILES];
    t_fstate                          r_fs_rd;

    logic                             w_own_we;
    logic [SW-1:0]                    w_own_waddr;
    logic [foa_pkg::OWNER_W-1:0]      w_own_wdata;
    logic                             w_own_re;
    logic                             w_fs_we;
    logic [FAW-1:0]                   w_fs_waddr;
    t_fstate                          w_fs_wdata;
    logic [FAW-1:0]                   w_fs_raddr;

    logic [12:0]                      w_in_fid_x;
    logic [12:0]                      w_r_fid_x;
    logic                             w_fid_bad;
    logic                             w_iv;
    logic                             w_alloc;
    logic [foa_pkg::OWNER_W-1:0]      w_want;
    logic                             w_match;
    logic                             w_stop;
    logic [CW-1:0]                    w_bc;
    logic [FW-1:0]                    w_bf;
    logic [FCW-1:0]                   w_bf1;
    logic [FCW-1:0]                   w_nf;
    logic [15:0]                      w_cart_x;
    logic [15:0]                      w_frame_x;
    logic [15:0]                      w_pos_x;

    assign w_in_fid_x = 13'(i_file_id);
    assign w_r_fid_x  = 13'(r_fid);
    assign w_fid_bad  = (i_file_id == '0) || (32'(i_file_id) >= MAX_FILES);
    assign w_iv       = (r_c < CCW'(CARTRIDGES));
    assign w_alloc    = (r_action == foa_pkg::ACT_OPEN) || (r_action == foa_pkg::ACT_EXTEND);
    assign w_want     = w_alloc ? '0 : r_fid;
    assign w_match    = (r_owner_rd == w_want);
    assign w_nf       = FCW'(r_f) + FCW'(1);
    assign w_fs_raddr = w_in_fid_x[FAW-1:0];

    // scan stops at a hit except for release, and for seek until the offset is used up
    always_comb begin
        unique case (r_action)
            foa_pkg::ACT_RELEASE: w_stop = 1'b0;
            foa_pkg::ACT_SEEK:    w_stop = (32'(r_rem) < FRAME_BYTES);
            default:              w_stop = 1'b1;
        endcase
    end

    // base frame of a forward scan
    always_comb begin
        if (r_action == foa_pkg::ACT_OPEN) begin
            w_bc = '0;
            w_bf = '0;
        end else if (r_action == foa_pkg::ACT_NEXT) begin
            w_bc = r_fs_rd.cur_c;
            w_bf = r_fs_rd.cur_f;
        end else begin
            w_bc = r_fs_rd.end_c;
            w_bf = r_fs_rd.end_f;
        end
    end
    assign w_bf1 = FCW'(w_bf) + FCW'(1);

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_action = r_action;
        n_fid    = r_fid;
        n_offset = r_offset;
        n_rem    = r_rem;
        n_cur_c  = r_cur_c;
        n_cur_f  = r_cur_f;
        n_cur_p  = r_cur_p;
        n_end_c  = r_end_c;
        n_end_f  = r_end_f;
        n_status = r_status;
        n_c      = r_c;
        n_f      = r_f;
        n_slot   = r_slot;
        n_skip0  = r_skip0;
        n_pv     = r_pv;
        n_pc     = r_pc;
        n_pf     = r_pf;
        n_pslot  = r_pslot;

        w_own_we    = 1'b0;
        w_own_waddr = r_pslot[SW-1:0];
        w_own_wdata = '0;
        w_own_re    = 1'b0;
        w_fs_we     = 1'b0;
        w_fs_waddr  = w_r_fid_x[FAW-1:0];
        w_fs_wdata  = '{cur_c: r_cur_c, cur_f: r_cur_f, cur_p: r_cur_p,
                        end_c: r_end_c, end_f: r_end_f};

        unique case (r_state)
            foa_pkg::S_CLEAR: begin
                w_own_we    = (32'(r_clr) < TABLE);
                w_own_waddr = r_clr[SW-1:0];
                w_fs_we     = (32'(r_clr) < MAX_FILES);
                w_fs_waddr  = r_clr[FAW-1:0];
                w_fs_wdata  = '0;
                n_clr       = r_clr + CLRW'(1);
                if (32'(r_clr) == CLR_N - 1) begin
                    n_state = foa_pkg::S_IDLE;
                end
            end
            foa_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_action = i_action;
                    n_fid    = i_file_id;
                    n_offset = i_offset;
                    if (w_fid_bad) begin
                        n_status = foa_pkg::ST_NONE;
                        n_cur_c  = '0;
                        n_cur_f  = '0;
                        n_cur_p  = '0;
                        n_state  = foa_pkg::S_OUT;
                    end else begin
                        n_state = foa_pkg::S_LOAD;
                    end
                end
            end
            foa_pkg::S_LOAD: begin
                n_cur_c  = r_fs_rd.cur_c;
                n_cur_f  = r_fs_rd.cur_f;
                n_cur_p  = r_fs_rd.cur_p;
                n_end_c  = r_fs_rd.end_c;
                n_end_f  = r_fs_rd.end_f;
                n_rem    = r_offset;
                n_status = foa_pkg::ST_DONE;
                n_pv     = 1'b0;
                if (w_bf1 == FCW'(FRAMES_PER_CARTRIDGE)) begin
                    n_c = CCW'(w_bc) + CCW'(1);
                    n_f = FW'(1);
                end else begin
                    n_c = CCW'(w_bc);
                    n_f = w_bf1[FW-1:0];
                end
                n_skip0 = 1'b1;
                n_state = foa_pkg::S_SETUP;
                unique case (r_action)
                    foa_pkg::ACT_OPEN: begin
                        n_end_c = '0;
                        n_end_f = '0;
                    end
                    foa_pkg::ACT_EXTEND: begin
                    end
                    foa_pkg::ACT_NEXT: begin
                        if ((r_fs_rd.cur_c == r_fs_rd.end_c) &&
                            (r_fs_rd.cur_f == r_fs_rd.end_f)) begin
                            n_status = foa_pkg::ST_AT_END;
                            n_state  = foa_pkg::S_WB;
                        end
                    end
                    foa_pkg::ACT_RELEASE, foa_pkg::ACT_SEEK: begin
                        n_c     = '0;
                        n_f     = '0;
                        n_skip0 = 1'b0;
                    end
                    default: begin
                        n_state = foa_pkg::S_WB;
                    end
                endcase
            end
            foa_pkg::S_SETUP: begin
                n_slot  = SCW'(r_c * FRAMES_PER_CARTRIDGE) + SCW'(r_f);
                n_state = foa_pkg::S_SCAN;
            end
            foa_pkg::S_SCAN: begin
                if (r_pv && w_match && w_stop) begin
                    n_cur_c = r_pc[CW-1:0];
                    n_cur_f = r_pf;
                    n_cur_p = '0;
                    if (w_alloc) begin
                        w_own_we    = 1'b1;
                        w_own_wdata = r_fid;
                        n_end_c     = r_pc[CW-1:0];
                        n_end_f     = r_pf;
                    end
                    if (r_action == foa_pkg::ACT_SEEK) begin
                        n_cur_p = r_rem[PW-1:0];
                    end
                    n_state = foa_pkg::S_WB;
                end else if (!w_iv && !r_pv) begin
                    n_status = (r_action == foa_pkg::ACT_RELEASE) ?
                               foa_pkg::ST_DONE : foa_pkg::ST_NONE;
                    n_state  = foa_pkg::S_WB;
                end else begin
                    if (r_pv && w_match) begin
                        if (r_action == foa_pkg::ACT_RELEASE) begin
                            w_own_we = 1'b1;
                        end else begin
                            n_rem = r_rem - OFW'(FRAME_BYTES);
                        end
                    end
                    w_own_re = w_iv;
                    n_pv     = w_iv;
                    n_pc     = r_c;
                    n_pf     = r_f;
                    n_pslot  = r_slot;
                    if (w_nf == FCW'(FRAMES_PER_CARTRIDGE)) begin
                        n_c    = r_c + CCW'(1);
                        n_f    = r_skip0 ? FW'(1) : '0;
                        n_slot = r_slot + (r_skip0 ? SCW'(2) : SCW'(1));
                    end else begin
                        n_f    = w_nf[FW-1:0];
                        n_slot = r_slot + SCW'(1);
                    end
                end
            end
            foa_pkg::S_WB: begin
                w_fs_we = 1'b1;
                n_state = foa_pkg::S_OUT;
            end
            foa_pkg::S_OUT: begin
                if (i_ready) begin
                    n_state = foa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = foa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= foa_pkg::S_CLEAR;
            r_clr   <= '0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_pv    <= n_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_fid    <= n_fid;
        r_offset <= n_offset;
        r_rem    <= n_rem;
        r_cur_c  <= n_cur_c;
        r_cur_f  <= n_cur_f;
        r_cur_p  <= n_cur_p;
        r_end_c  <= n_end_c;
        r_end_f  <= n_end_f;
        r_status <= n_status;
        r_c      <= n_c;
        r_f      <= n_f;
        r_slot   <= n_slot;
        r_skip0  <= n_skip0;
        r_pc     <= n_pc;
        r_pf     <= n_pf;
        r_pslot  <= n_pslot;
    end

    // owner table
    always_ff @(posedge i_clk) begin
        if (w_own_we) begin
            r_owner_mem[w_own_waddr] <= w_own_wdata;
        end
        if (w_own_re) begin
            r_owner_rd <= r_owner_mem[r_slot[SW-1:0]];
        end
    end

    // per-file cursor and end frame
    always_ff @(posedge i_clk) begin
        if (w_fs_we) begin
            r_file_mem[w_fs_waddr] <= w_fs_wdata;
        end
        r_fs_rd <= r_file_mem[w_fs_raddr];
    end

    assign w_cart_x  = 16'(r_cur_c);
    assign w_frame_x = 16'(r_cur_f);
    assign w_pos_x   = 16'(r_cur_p);

    assign o_ready     = (r_state == foa_pkg::S_IDLE);
    assign o_valid     = (r_state == foa_pkg::S_OUT);
    assign o_status    = r_status;
    assign o_cartridge = w_cart_x[foa_pkg::CART_OUT_W-1:0];
    assign o_frame     = w_frame_x[foa_pkg::FRAME_OUT_W-1:0];
    assign o_position  = w_pos_x[foa_pkg::POS_OUT_W-1:0];

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("item accepted while another item is in progress");

    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == foa_pkg::S_CLEAR) |-> (!o_ready && !o_valid))
        else $error("handshake active during clearing pass");

    a_alloc_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_own_we && (w_own_wdata != '0)) |->
        ((r_state == foa_pkg::S_SCAN) && r_pv && (r_owner_rd == '0)))
        else $error("frame given to a file while not free");

    a_at_end_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == foa_pkg::ST_AT_END)) |-> (r_action == foa_pkg::ACT_NEXT))
        else $error("end status for an action other than next");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the frame ownership allocator. A scoreboard class
// keeps its own owner table, file cursors and end frames, predicts the reply
// to every accepted item and compares replies field by field. Stimulus is a
// directed pass over invalid files, unknown actions, end-of-file and seek
// corner cases, followed by a random mix of file traffic that also holds invalid file ids and unknown actions.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

    localparam int N_CART    = 64;
    localparam int N_FRAME   = 1024;
    localparam int N_FILES   = 1024;
    localparam int FRAME_SZ  = 1024;
    localparam int ACT_W     = foa_pkg::ACTION_W;
    localparam int OFF_W     = foa_pkg::OFFSET_W;
    localparam int OWN_W     = foa_pkg::OWNER_W;
    localparam int CART_W    = foa_pkg::CART_OUT_W;
    localparam int FRM_W     = foa_pkg::FRAME_OUT_W;
    localparam int POS_W     = foa_pkg::POS_OUT_W;
    localparam int unsigned CYCLE_LIMIT = 40_000_000;

    typedef struct packed {
        logic [foa_pkg::STATUS_W-1:0]    status;
        logic [foa_pkg::CART_OUT_W-1:0]  cart;
        logic [foa_pkg::FRAME_OUT_W-1:0] frame;
        logic [foa_pkg::POS_OUT_W-1:0]   pos;
    } frame_reply_t;

    class alloc_scoreboard;
        bit [foa_pkg::OWNER_W-1:0]     owner_map[];
        bit [foa_pkg::CART_OUT_W-1:0]  cur_cart[];
        bit [foa_pkg::FRAME_OUT_W-1:0] cur_frame[];
        bit [foa_pkg::POS_OUT_W-1:0]   cur_pos[];
        bit [foa_pkg::CART_OUT_W-1:0]  end_cart[];
        bit [foa_pkg::FRAME_OUT_W-1:0] end_frame[];
        int                            frames_held[];
        frame_reply_t                  pending_replies[$];
        int                            errors;

        function new();
            owner_map   = new[N_CART * N_FRAME];
            cur_cart    = new[N_FILES];
            cur_frame   = new[N_FILES];
            cur_pos     = new[N_FILES];
            end_cart    = new[N_FILES];
            end_frame   = new[N_FILES];
            frames_held = new[N_FILES];
            errors      = 0;
        endfunction

        // forward scan after (c0,f0); a new cartridge restarts at frame 1
        function bit find_after(input int c0, input int f0,
                                input bit [foa_pkg::OWNER_W-1:0] want,
                                output int oc, output int of);
            int c;
            int f;
            int first;
            first = f0 + 1;
            oc = 0;
            of = 0;
            for (c = c0; c < N_CART; c++) begin
                for (f = first; f < N_FRAME; f++) begin
                    if (owner_map[c * N_FRAME + f] == want) begin
                        oc = c;
                        of = f;
                        return 1'b1;
                    end
                end
                first = 1;
            end
            return 1'b0;
        endfunction

        function bit [foa_pkg::STATUS_W-1:0] grant(input int id);
            int c;
            int f;
            if (!find_after(int'(end_cart[id]), int'(end_frame[id]), '0, c, f))
                return foa_pkg::ST_NONE;
            owner_map[c * N_FRAME + f] = OWN_W'(id);
            cur_cart[id]  = CART_W'(c);
            cur_frame[id] = FRM_W'(f);
            cur_pos[id]   = '0;
            end_cart[id]  = CART_W'(c);
            end_frame[id] = FRM_W'(f);
            frames_held[id]++;
            return foa_pkg::ST_DONE;
        endfunction

        function bit [foa_pkg::STATUS_W-1:0] advance(input int id);
            int c;
            int f;
            if (cur_cart[id] == end_cart[id] && cur_frame[id] == end_frame[id])
                return foa_pkg::ST_AT_END;
            if (!find_after(int'(cur_cart[id]), int'(cur_frame[id]), OWN_W'(id), c, f))
                return foa_pkg::ST_NONE;
            cur_cart[id]  = CART_W'(c);
            cur_frame[id] = FRM_W'(f);
            cur_pos[id]   = '0;
            return foa_pkg::ST_DONE;
        endfunction

        function void free_all(input int id);
            int k;
            for (k = 0; k < N_CART * N_FRAME; k++)
                if (owner_map[k] == id)
                    owner_map[k] = '0;
            frames_held[id] = 0;
        endfunction

        function bit [foa_pkg::STATUS_W-1:0] locate(input int id, input int unsigned offset);
            int unsigned wanted;
            int unsigned seen;
            int k;
            wanted = offset / FRAME_SZ;
            seen = 0;
            for (k = 0; k < N_CART * N_FRAME; k++) begin
                if (owner_map[k] == id) begin
                    if (seen == wanted) begin
                        cur_cart[id]  = CART_W'(k / N_FRAME);
                        cur_frame[id] = FRM_W'(k % N_FRAME);
                        cur_pos[id]   = POS_W'(offset % FRAME_SZ);
                        return foa_pkg::ST_DONE;
                    end
                    seen++;
                end
            end
            return foa_pkg::ST_NONE;
        endfunction

        function void note_input(input bit [foa_pkg::ACTION_W-1:0] action,
                                 input bit [foa_pkg::FILE_ID_W-1:0] fid,
                                 input bit [foa_pkg::OFFSET_W-1:0] offset);
            frame_reply_t r;
            bit [foa_pkg::STATUS_W-1:0] st;
            int id;
            id = int'(fid);
            st = foa_pkg::ST_DONE;
            if (id == 0 || id >= N_FILES) begin
                r.status = foa_pkg::ST_NONE;
                r.cart   = '0;
                r.frame  = '0;
                r.pos    = '0;
            end else begin
                case (action)
                    foa_pkg::ACT_OPEN: begin
                        end_cart[id]  = '0;
                        end_frame[id] = '0;
                        st = grant(id);
                    end
                    foa_pkg::ACT_EXTEND:  st = grant(id);
                    foa_pkg::ACT_NEXT:    st = advance(id);
                    foa_pkg::ACT_RELEASE: free_all(id);
                    foa_pkg::ACT_SEEK:    st = locate(id, 32'(offset));
                    default:              st = foa_pkg::ST_DONE;
                endcase
                r.status = st;
                r.cart   = cur_cart[id];
                r.frame  = cur_frame[id];
                r.pos    = cur_pos[id];
            end
            pending_replies.push_back(r);
        endfunction

        function void check_result(input bit [foa_pkg::STATUS_W-1:0] st,
                                   input bit [foa_pkg::CART_OUT_W-1:0] c,
                                   input bit [foa_pkg::FRAME_OUT_W-1:0] f,
                                   input bit [foa_pkg::POS_OUT_W-1:0] p);
            frame_reply_t want;
            if (pending_replies.size() == 0) begin
                $error("result item with no item outstanding");
                errors++;
                return;
            end
            want = pending_replies.pop_front();
            if (st != want.status) begin
                $error("status: expected %0d, actual %0d", want.status, st);
                errors++;
            end
            if (c != want.cart) begin
                $error("cartridge: expected %0d, actual %0d", want.cart, c);
                errors++;
            end
            if (f != want.frame) begin
                $error("frame: expected %0d, actual %0d", want.frame, f);
                errors++;
            end
            if (p != want.pos) begin
                $error("position: expected %0d, actual %0d", want.pos, p);
                errors++;
            end
        endfunction

        function int held(input int id);
            return frames_held[id];
        endfunction

        function bit idle();
            return pending_replies.size() == 0;
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_valid;
    logic                            o_ready;
    logic [foa_pkg::ACTION_W-1:0]    i_action;
    logic [foa_pkg::FILE_ID_W-1:0]   i_file_id;
    logic [foa_pkg::OFFSET_W-1:0]    i_offset;
    logic                            o_valid;
    logic                            i_ready;
    logic [foa_pkg::STATUS_W-1:0]    o_status;
    logic [foa_pkg::CART_OUT_W-1:0]  o_cartridge;
    logic [foa_pkg::FRAME_OUT_W-1:0] o_frame;
    logic [foa_pkg::POS_OUT_W-1:0]   o_position;

    alloc_scoreboard sb;
    int              burst_left;
    int              ready_mode = 0;
    int              ready_left = 0;
    int unsigned     cycles = 0;

    frame_ownership_allocator #(
        .CARTRIDGES          (N_CART),
        .FRAMES_PER_CARTRIDGE(N_FRAME),
        .MAX_FILES           (N_FILES),
        .FRAME_BYTES         (FRAME_SZ)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_action   (i_action),
        .i_file_id  (i_file_id),
        .i_offset   (i_offset),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_status   (o_status),
        .o_cartridge(o_cartridge),
        .o_frame    (o_frame),
        .o_position (o_position)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver stall pattern: free-running, coin flips, or one beat in eight
    always @(negedge i_clk) begin
        if (ready_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            ready_left = $urandom_range(4, 40);
        end
        ready_left--;
        case (ready_mode)
            0:       i_ready = 1'b1;
            1:       i_ready = ($urandom_range(0, 1) == 1);
            default: i_ready = (ready_left % 8 == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result(o_status, o_cartridge, o_frame, o_position);
    end

    task automatic send_item(input bit [foa_pkg::ACTION_W-1:0] action,
                             input bit [foa_pkg::FILE_ID_W-1:0] fid,
                             input bit [foa_pkg::OFFSET_W-1:0] offset);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                              : $urandom_range(0, 4);
        end
        burst_left--;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   = 1'b1;
        i_action  = action;
        i_file_id = fid;
        i_offset  = offset;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(action, fid, offset);
    endtask

    function automatic bit [foa_pkg::FILE_ID_W-1:0] pick_file();
        case ($urandom_range(0, 4))
            0:       return 10'd1;
            1:       return 10'd1023;
            2:       return 10'd5;
            3:       return 10'd341;
            default: return 10'd682;
        endcase
    endfunction

    task automatic run_random(input int count);
        int k;
        int r;
        int n;
        bit [foa_pkg::FILE_ID_W-1:0] fid;
        for (k = 0; k < count; k++) begin
            fid = pick_file();
            r = $urandom_range(0, 99);
            n = sb.held(int'(fid));
            if (r < 3)
                send_item(ACT_W'($urandom_range(0, 7)), '0, OFF_W'($urandom));
            else if (r < 6)
                send_item(ACT_W'($urandom_range(5, 7)), fid, OFF_W'($urandom));
            else if (r < 20)
                send_item(foa_pkg::ACT_OPEN, fid, OFF_W'($urandom));
            else if (r < 50)
                send_item(foa_pkg::ACT_EXTEND, fid, OFF_W'($urandom));
            else if (r < 70)
                send_item(foa_pkg::ACT_NEXT, fid, OFF_W'($urandom));
            else if (r < 90) begin
                if (n > 0)
                    send_item(foa_pkg::ACT_SEEK, fid,
                              OFF_W'($urandom_range(0, n * FRAME_SZ - 1)));
                else
                    send_item(foa_pkg::ACT_EXTEND, fid, OFF_W'($urandom));
            end else if (r < 94)
                send_item(foa_pkg::ACT_RELEASE, fid, OFF_W'($urandom));
            else
                send_item(foa_pkg::ACT_SEEK, fid, OFF_W'($urandom));
        end
    endtask

    initial begin
        sb         = new();
        burst_left = 0;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_action   = '0;
        i_file_id  = '0;
        i_offset   = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // invalid file, fresh file at its end, unknown actions
        send_item(foa_pkg::ACT_OPEN, '0, '0);
        send_item(3'd7, '0, {foa_pkg::OFFSET_W{1'b1}});
        send_item(foa_pkg::ACT_NEXT, 10'd5, '0);
        send_item(3'd5, 10'd5, '0);
        send_item(foa_pkg::ACT_SEEK, 10'd5, '0);
        // two files interleaved at the start of the table
        send_item(foa_pkg::ACT_OPEN, 10'd1023, '0);
        send_item(foa_pkg::ACT_EXTEND, 10'd1023, '0);
        send_item(foa_pkg::ACT_OPEN, 10'd1, '0);
        send_item(foa_pkg::ACT_EXTEND, 10'd1023, '0);
        send_item(foa_pkg::ACT_EXTEND, 10'd1023, '0);
        send_item(foa_pkg::ACT_SEEK, 10'd1023, '0);
        send_item(foa_pkg::ACT_NEXT, 10'd1023, '0);
        send_item(foa_pkg::ACT_NEXT, 10'd1023, '0);
        send_item(foa_pkg::ACT_NEXT, 10'd1023, '0);
        send_item(foa_pkg::ACT_NEXT, 10'd1023, '0);
        send_item(foa_pkg::ACT_SEEK, 10'd1023, OFF_W'(3 * FRAME_SZ + FRAME_SZ - 1));
        send_item(foa_pkg::ACT_SEEK, 10'd1023, {foa_pkg::OFFSET_W{1'b1}});
        send_item(3'd6, 10'd1023, '0);
        // freed frames and stale cursors
        send_item(foa_pkg::ACT_RELEASE, 10'd1, '0);
        send_item(foa_pkg::ACT_EXTEND, 10'd1, '0);
        send_item(foa_pkg::ACT_OPEN, 10'd1, '0);
        send_item(foa_pkg::ACT_SEEK, 10'd1023, '0);
        send_item(foa_pkg::ACT_RELEASE, 10'd1023, '0);
        send_item(foa_pkg::ACT_NEXT, 10'd1023, '0);
        send_item(foa_pkg::ACT_OPEN, 10'd1023, '0);

        run_random(75);

        @(negedge i_clk);
        i_valid = 1'b0;
        while (!sb.idle()) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
